// ----- hw/rtl/wav_hdr_pkg.sv -----
package wav_hdr_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NOT_RIFF  = 3'd1;
  localparam logic [2:0] STATUS_NOT_WAVE  = 3'd2;
  localparam logic [2:0] STATUS_NO_DATA   = 3'd3;
  localparam logic [2:0] STATUS_SHORT_FMT = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] riff_size;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] bytes_per_second;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_t;

endpackage

// ----- hw/rtl/wav_header_parser_unit.sv -----
// Channel  | Dir | tdata                                  | tuser       | tlast
// s_axis   | in  | file_byte[7:0]                         | first_byte  | last_byte
// m_axis   | out | riff_size .. data_size (224 bits)      | status[2:0] | -
//
// One byte is taken per cycle while s_axis_tready is high; the header state is updated in the same cycle.
// A result is registered (in the skid if the output register still waits) before it shows on m_axis.
// A two-entry output (register plus skid) keeps s_axis_tready high while one
// result waits; only a second pending result stalls the input.
// rst is synchronous and puts the parser in the state that expects byte 0.
module wav_header_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] file_byte
  input  logic         s_axis_tuser,   // [0] first_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [223:0] m_axis_tdata,   // riff_size, format_tag, channels, sample_rate,
                                       // bytes_per_second, block_align, bits_per_sample,
                                       // data_offset, data_size (lowest bit up)
  output logic [2:0]   m_axis_tuser    // [2:0] status
);

  localparam logic [3:0] PH_RIFF   = 4'd0;
  localparam logic [3:0] PH_RSIZE  = 4'd1;
  localparam logic [3:0] PH_WAVE   = 4'd2;
  localparam logic [3:0] PH_FMTID  = 4'd3;
  localparam logic [3:0] PH_FLEN   = 4'd4;
  localparam logic [3:0] PH_FIELDS = 4'd5;
  localparam logic [3:0] PH_SKIP   = 4'd6;
  localparam logic [3:0] PH_CID    = 4'd7;
  localparam logic [3:0] PH_CSIZE  = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;

  logic [3:0]  phase, phase_next;
  logic [31:0] byte_pos, byte_pos_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] gather, gather_next;
  logic [4:0]  sect_cnt, sect_cnt_next;
  logic [31:0] skip_rem, skip_rem_next;
  logic [31:0] fmt_len, fmt_len_next;
  logic [31:0] riff_size, riff_size_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channels, channels_next;
  logic [31:0] rate, rate_next;
  logic [31:0] byte_rate, byte_rate_next;
  logic [15:0] align, align_next;
  logic [15:0] sample_bits, sample_bits_next;

  logic                 in_fire;
  logic                 res_fire;
  wav_hdr_pkg::result_t res;

  logic                 out_valid;
  wav_hdr_pkg::result_t out_data;
  logic                 skid_valid;
  wav_hdr_pkg::result_t skid_data;

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [3:0]  ph;
    logic [4:0]  cnt_inc;
    logic        done4;
    logic        have_status;
    logic        idle_step;
    logic [2:0]  st;
    logic [31:0] d_off;
    logic [31:0] d_size;

    if (s_axis_tuser) begin
      ph               = PH_RIFF;
      byte_pos_next    = '0;
      tag_shift_next   = '0;
      gather_next      = '0;
      sect_cnt_next    = '0;
      skip_rem_next    = '0;
      fmt_len_next     = '0;
      riff_size_next   = '0;
      format_tag_next  = '0;
      channels_next    = '0;
      rate_next        = '0;
      byte_rate_next   = '0;
      align_next       = '0;
      sample_bits_next = '0;
    end else begin
      ph               = phase;
      byte_pos_next    = byte_pos;
      tag_shift_next   = tag_shift;
      gather_next      = gather;
      sect_cnt_next    = sect_cnt;
      skip_rem_next    = skip_rem;
      fmt_len_next     = fmt_len;
      riff_size_next   = riff_size;
      format_tag_next  = format_tag;
      channels_next    = channels;
      rate_next        = rate;
      byte_rate_next   = byte_rate;
      align_next       = align;
      sample_bits_next = sample_bits;
    end
    phase_next  = ph;
    have_status = 1'b0;
    idle_step   = 1'b0;
    st          = wav_hdr_pkg::STATUS_OK;
    d_off       = '0;
    d_size      = '0;

    if (ph == PH_RIFF || ph == PH_WAVE || ph == PH_FMTID || ph == PH_CID) begin
      tag_shift_next = {s_axis_tdata, tag_shift_next[31:8]};
    end else if (ph != PH_DONE) begin
      gather_next = {s_axis_tdata, gather_next[31:8]};
    end

    cnt_inc = sect_cnt_next + 5'd1;
    done4   = (cnt_inc >= 5'd4);

    case (ph)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMTID, PH_FLEN, PH_CID, PH_CSIZE: begin
        sect_cnt_next = done4 ? 5'd0 : cnt_inc;
        if (done4) begin
          case (ph)
            PH_RIFF: begin
              if (tag_shift_next != wav_hdr_pkg::TAG_RIFF) begin
                have_status = 1'b1;
                st          = wav_hdr_pkg::STATUS_NOT_RIFF;
              end else begin
                phase_next = PH_RSIZE;
              end
            end
            PH_RSIZE: begin
              riff_size_next = gather_next;
              phase_next     = PH_WAVE;
            end
            PH_WAVE: begin
              if (tag_shift_next != wav_hdr_pkg::TAG_WAVE) begin
                have_status = 1'b1;
                st          = wav_hdr_pkg::STATUS_NOT_WAVE;
              end else begin
                phase_next = PH_FMTID;
              end
            end
            PH_FMTID: phase_next = PH_FLEN;
            PH_FLEN: begin
              fmt_len_next = gather_next;
              if (gather_next < 32'd16) begin
                have_status = 1'b1;
                st          = wav_hdr_pkg::STATUS_SHORT_FMT;
              end else begin
                phase_next = PH_FIELDS;
              end
            end
            PH_CID: phase_next = PH_CSIZE;
            default: begin
              if (tag_shift_next == wav_hdr_pkg::TAG_DATA) begin
                have_status = 1'b1;
                st          = wav_hdr_pkg::STATUS_OK;
                d_size      = gather_next;
                d_off       = byte_pos_next + 32'd1;
              end else begin
                skip_rem_next = gather_next;
                phase_next    = (gather_next != '0) ? PH_SKIP : PH_CID;
              end
            end
          endcase
        end
      end
      PH_FIELDS: begin
        case (sect_cnt_next)
          5'd1:    format_tag_next  = gather_next[31:16];
          5'd3:    channels_next    = gather_next[31:16];
          5'd7:    rate_next        = gather_next;
          5'd11:   byte_rate_next   = gather_next;
          5'd13:   align_next       = gather_next[31:16];
          5'd15:   sample_bits_next = gather_next[31:16];
          default: ;
        endcase
        if (cnt_inc >= 5'd16) begin
          sect_cnt_next = '0;
          skip_rem_next = fmt_len_next - 32'd16;
          phase_next    = (fmt_len_next != 32'd16) ? PH_SKIP : PH_CID;
        end else begin
          sect_cnt_next = cnt_inc;
        end
      end
      PH_SKIP: begin
        skip_rem_next = skip_rem_next - 32'd1;
        if (skip_rem_next == 32'd0) begin
          phase_next = PH_CID;
        end
      end
      PH_DONE: idle_step = 1'b1;
      default: begin
        idle_step  = 1'b1;
        phase_next = PH_DONE;
      end
    endcase

    if (!idle_step) begin
      byte_pos_next = byte_pos_next + 32'd1;
      if (!have_status && s_axis_tlast) begin
        have_status = 1'b1;
        st          = wav_hdr_pkg::STATUS_NO_DATA;
      end
      if (have_status) begin
        phase_next = PH_DONE;
      end
    end

    res_fire             = have_status;
    res.status           = st;
    res.riff_size        = riff_size_next;
    res.format_tag       = format_tag_next;
    res.channels         = channels_next;
    res.sample_rate      = rate_next;
    res.bytes_per_second = byte_rate_next;
    res.block_align      = align_next;
    res.bits_per_sample  = sample_bits_next;
    res.data_offset      = d_off;
    res.data_size        = d_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RIFF;
      byte_pos    <= '0;
      tag_shift   <= '0;
      gather      <= '0;
      sect_cnt    <= '0;
      skip_rem    <= '0;
      fmt_len     <= '0;
      riff_size   <= '0;
      format_tag  <= '0;
      channels    <= '0;
      rate        <= '0;
      byte_rate   <= '0;
      align       <= '0;
      sample_bits <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      byte_pos    <= byte_pos_next;
      tag_shift   <= tag_shift_next;
      gather      <= gather_next;
      sect_cnt    <= sect_cnt_next;
      skip_rem    <= skip_rem_next;
      fmt_len     <= fmt_len_next;
      riff_size   <= riff_size_next;
      format_tag  <= format_tag_next;
      channels    <= channels_next;
      rate        <= rate_next;
      byte_rate   <= byte_rate_next;
      align       <= align_next;
      sample_bits <= sample_bits_next;
    end
  end

  // output register plus skid; input stalls only when both hold a result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire && res_fire) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && m_axis_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) begin
      if (!out_valid || m_axis_tready) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end else if (out_valid && m_axis_tready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_data.status;
  assign m_axis_tdata  = {out_data.data_size, out_data.data_offset,
                          out_data.bits_per_sample, out_data.block_align,
                          out_data.bytes_per_second, out_data.sample_rate,
                          out_data.channels, out_data.format_tag,
                          out_data.riff_size};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_fire) |=> m_axis_tvalid)
    else $error("result beat not presented");

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_fire) |=> (phase == PH_DONE))
    else $error("parser not parked after result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= wav_hdr_pkg::STATUS_SHORT_FMT))
    else $error("status code out of range");

endmodule

// ----- tb/wav_header_checker.sv -----
`timescale 1ns / 1ps

module wav_header_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [223:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  output int           mismatches,
  output int           pending
);

  typedef enum logic [3:0] {
    WANT_RIFF,
    WANT_RIFF_SIZE,
    WANT_WAVE,
    WANT_FMT_ID,
    WANT_FMT_LEN,
    WANT_FIELDS,
    SKIPPING,
    WANT_CHUNK_ID,
    WANT_CHUNK_SIZE,
    FILE_DONE
  } parse_phase_t;

  wav_hdr_pkg::result_t expected_hdrs[$];

  parse_phase_t phase;
  logic [31:0]  file_pos;
  logic [31:0]  tag_sr;
  logic [31:0]  gather;
  logic [4:0]   sec_cnt;
  logic [31:0]  skip_left;
  logic [31:0]  fmt_len;
  logic [31:0]  h_riff;
  logic [15:0]  h_tag;
  logic [15:0]  h_chan;
  logic [31:0]  h_rate;
  logic [31:0]  h_brate;
  logic [15:0]  h_align;
  logic [15:0]  h_bits;

  function automatic void clear_parser();
    phase     = WANT_RIFF;
    file_pos  = '0;
    tag_sr    = '0;
    gather    = '0;
    sec_cnt   = '0;
    skip_left = '0;
    fmt_len   = '0;
    h_riff    = '0;
    h_tag     = '0;
    h_chan    = '0;
    h_rate    = '0;
    h_brate   = '0;
    h_align   = '0;
    h_bits    = '0;
  endfunction

  // four-byte section counter
  function automatic bit quad_done();
    sec_cnt = sec_cnt + 5'd1;
    if (sec_cnt >= 5'd4) begin
      sec_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_header(input logic [7:0] b, input logic first, input logic last);
    logic                 have;
    logic [2:0]           st;
    logic [31:0]          off;
    logic [31:0]          dsize;
    wav_hdr_pkg::result_t r;
    have  = 1'b0;
    st    = wav_hdr_pkg::STATUS_OK;
    off   = '0;
    dsize = '0;
    if (first) clear_parser();
    if (phase == FILE_DONE) return;

    if (phase inside {WANT_RIFF, WANT_WAVE, WANT_FMT_ID, WANT_CHUNK_ID})
      tag_sr = {b, tag_sr[31:8]};
    else
      gather = {b, gather[31:8]};

    case (phase)
      WANT_RIFF: begin
        if (quad_done()) begin
          if (tag_sr != wav_hdr_pkg::TAG_RIFF) begin
            have = 1'b1;
            st   = wav_hdr_pkg::STATUS_NOT_RIFF;
          end else phase = WANT_RIFF_SIZE;
        end
      end
      WANT_RIFF_SIZE: begin
        if (quad_done()) begin
          h_riff = gather;
          phase  = WANT_WAVE;
        end
      end
      WANT_WAVE: begin
        if (quad_done()) begin
          if (tag_sr != wav_hdr_pkg::TAG_WAVE) begin
            have = 1'b1;
            st   = wav_hdr_pkg::STATUS_NOT_WAVE;
          end else phase = WANT_FMT_ID;
        end
      end
      WANT_FMT_ID: begin
        if (quad_done()) phase = WANT_FMT_LEN;
      end
      WANT_FMT_LEN: begin
        if (quad_done()) begin
          fmt_len = gather;
          if (fmt_len < 32'd16) begin
            have = 1'b1;
            st   = wav_hdr_pkg::STATUS_SHORT_FMT;
          end else phase = WANT_FIELDS;
        end
      end
      WANT_FIELDS: begin
        case (sec_cnt)
          5'd1:  h_tag   = gather[31:16];
          5'd3:  h_chan  = gather[31:16];
          5'd7:  h_rate  = gather;
          5'd11: h_brate = gather;
          5'd13: h_align = gather[31:16];
          5'd15: h_bits  = gather[31:16];
          default: ;
        endcase
        sec_cnt = sec_cnt + 5'd1;
        if (sec_cnt >= 5'd16) begin
          sec_cnt   = '0;
          skip_left = fmt_len - 32'd16;
          phase     = (skip_left != 0) ? SKIPPING : WANT_CHUNK_ID;
        end
      end
      SKIPPING: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) phase = WANT_CHUNK_ID;
      end
      WANT_CHUNK_ID: begin
        if (quad_done()) phase = WANT_CHUNK_SIZE;
      end
      WANT_CHUNK_SIZE: begin
        if (quad_done()) begin
          if (tag_sr == wav_hdr_pkg::TAG_DATA) begin
            have  = 1'b1;
            st    = wav_hdr_pkg::STATUS_OK;
            dsize = gather;
            off   = file_pos + 32'd1;
          end else begin
            skip_left = gather;
            phase     = (skip_left != 0) ? SKIPPING : WANT_CHUNK_ID;
          end
        end
      end
      default: ;
    endcase

    file_pos = file_pos + 32'd1;

    if (!have && last) begin
      have = 1'b1;
      st   = wav_hdr_pkg::STATUS_NO_DATA;
    end
    if (have) begin
      r.status           = st;
      r.riff_size        = h_riff;
      r.format_tag       = h_tag;
      r.channels         = h_chan;
      r.sample_rate      = h_rate;
      r.bytes_per_second = h_brate;
      r.block_align      = h_align;
      r.bits_per_sample  = h_bits;
      r.data_offset      = off;
      r.data_size        = dsize;
      expected_hdrs.push_back(r);
      phase = FILE_DONE;
    end
  endtask

  function automatic int field_diff(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_header();
    wav_hdr_pkg::result_t want;
    int                   bad;
    if (expected_hdrs.size() == 0) begin
      $display("%0t: unexpected result beat: status %h data %h",
               $time, m_axis_tuser, m_axis_tdata);
      mismatches++;
      return;
    end
    want = expected_hdrs.pop_front();
    bad  = field_diff("status", 32'(want.status), 32'(m_axis_tuser));
    bad += field_diff("riff_size", want.riff_size, m_axis_tdata[31:0]);
    bad += field_diff("format_tag", 32'(want.format_tag), 32'(m_axis_tdata[47:32]));
    bad += field_diff("channels", 32'(want.channels), 32'(m_axis_tdata[63:48]));
    bad += field_diff("sample_rate", want.sample_rate, m_axis_tdata[95:64]);
    bad += field_diff("bytes_per_second", want.bytes_per_second, m_axis_tdata[127:96]);
    bad += field_diff("block_align", 32'(want.block_align), 32'(m_axis_tdata[143:128]));
    bad += field_diff("bits_per_sample", 32'(want.bits_per_sample),
                      32'(m_axis_tdata[159:144]));
    bad += field_diff("data_offset", want.data_offset, m_axis_tdata[191:160]);
    bad += field_diff("data_size", want.data_size, m_axis_tdata[223:192]);
    mismatches += bad;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_hdrs.delete();
      mismatches = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_header(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        check_header();
    end
    pending = expected_hdrs.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam logic [31:0] FMT_ID         = 32'h2074_6d66;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          TARGET_BYTES   = 1400;
  localparam int          TARGET_FILES   = 20;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  int mismatches;
  int pending;

  int idle_pct_by_phase[4]  = '{0, 70, 0, 6};
  int stall_pct_by_phase[4] = '{0, 0, 70, 6};
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit hold_req      = 1'b0;
  int bytes_sent    = 0;
  int files_sent    = 0;
  int quiet_cycles  = 0;

  logic [7:0] file_bytes[$];

  always #1 clk = ~clk;

  wav_header_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  wav_header_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // result sink; a hold request blocks it for a long stretch
  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
    end
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [31:0] edge_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      4:       return 32'h0000_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // format fields, lowest byte first: tag, channels, rate, byte rate, align, bits
  function automatic logic [127:0] rand_fields();
    logic [31:0] t, c, a, s;
    t = edge_word();
    c = edge_word();
    a = edge_word();
    s = edge_word();
    return {s[15:0], a[15:0], edge_word(), edge_word(), c[15:0], t[15:0]};
  endfunction

  function automatic logic [31:0] junk_id();
    logic [31:0] id;
    if ($urandom_range(3) == 0)
      return wav_hdr_pkg::TAG_DATA ^ (32'd1 << $urandom_range(31));
    do id = $urandom; while (id == wav_hdr_pkg::TAG_DATA);
    return id;
  endfunction

  task automatic put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic header_prefix(input logic [31:0] riff, input logic [31:0] fmt_id,
                               input logic [31:0] flen);
    put32(wav_hdr_pkg::TAG_RIFF);
    put32(riff);
    put32(wav_hdr_pkg::TAG_WAVE);
    put32(fmt_id);
    put32(flen);
  endtask

  task automatic put_fields(input logic [127:0] fields);
    for (int i = 0; i < 16; i++) file_bytes.push_back(fields[8*i +: 8]);
  endtask

  // flen is kept in 16..22 here
  task automatic append_wav(input logic [31:0] riff, input logic [31:0] fmt_id,
                            input logic [31:0] flen, input logic [127:0] fields,
                            input int n_junk, input logic [31:0] dsize);
    int sz;
    header_prefix(riff, fmt_id, flen);
    put_fields(fields);
    put_rand(int'(flen) - 16);
    repeat (n_junk) begin
      put32(junk_id());
      sz = $urandom_range(0, 6);
      put32(32'(sz));
      put_rand(sz);
    end
    put32(wav_hdr_pkg::TAG_DATA);
    put32(dsize);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_file(input logic first_flag, input int last_at);
    foreach (file_bytes[i]) send_byte(file_bytes[i], first_flag && (i == 0), i == last_at);
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_file();
    int          sel;
    int          n;
    int          k;
    logic [31:0] flen;
    logic [31:0] short_len;
    sel  = $urandom_range(99);
    flen = ($urandom_range(3) == 0) ? 32'd16 + $urandom_range(1, 6) : 32'd16;
    if (sel < 90) begin
      append_wav(edge_word(), ($urandom_range(4) == 0) ? $urandom : FMT_ID, flen,
                 rand_fields(), $urandom_range(0, 2), edge_word());
      if (sel >= 70 && sel < 78) begin
        file_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      end else if (sel >= 78 && sel < 84) begin
        file_bytes[$urandom_range(8, 11)] ^= 8'($urandom_range(1, 255));
      end else if (sel >= 84) begin
        short_len = $urandom_range(0, 15);
        for (int i = 0; i < 4; i++) file_bytes[16 + i] = short_len[8*i +: 8];
      end
      n = file_bytes.size();
      put_rand($urandom_range(0, 3));
      k = $urandom_range(99);
      send_file(1'b1, (k < 25) ? $urandom_range(0, n - 1) : ((k < 40) ? n - 1 : -1));
    end else if (sel < 95) begin
      // abandoned file, the next one restarts the parser
      append_wav(edge_word(), FMT_ID, flen, rand_fields(), $urandom_range(0, 2), edge_word());
      file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 2)];
      send_file(1'b1, -1);
    end else begin
      put_rand($urandom_range(8, 24));
      foreach (file_bytes[i])
        send_byte(file_bytes[i], $urandom_range(3) == 0, $urandom_range(7) == 0);
      file_bytes.delete();
      files_sent++;
    end
  endtask

  initial begin
    int mode;
    int last_mode;
    int rnd_files;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no first flag after reset, all-zero header
    append_wav(32'd0, FMT_ID, 32'd16, '0, 0, 32'd0);
    send_file(1'b0, -1);
    // ignored after a result, last flag included
    put_rand(3);
    send_file(1'b0, 2);
    // all-ones fields, skip in format chunk, last on the completing byte
    append_wav(32'hFFFF_FFFF, wav_hdr_pkg::TAG_DATA, 32'd18, {128{1'b1}}, 1,
               32'hFFFF_FFFF);
    send_file(1'b1, file_bytes.size() - 1);
    // bad RIFF tag, last on the same byte
    put32(wav_hdr_pkg::TAG_RIFF ^ 32'h0100_0000);
    put32(32'd0);
    send_file(1'b1, 3);
    // bad WAVE tag
    put32(wav_hdr_pkg::TAG_RIFF);
    put32(32'h0000_1234);
    put32(wav_hdr_pkg::TAG_WAVE ^ 32'h0000_0001);
    send_file(1'b1, -1);
    // format chunk too short
    header_prefix(32'h24, FMT_ID, 32'd0);
    send_file(1'b1, -1);
    header_prefix(32'h24, FMT_ID, 32'd15);
    put_rand(4);
    send_file(1'b1, -1);
    // end on the very first byte
    file_bytes.push_back(8'h52);
    send_file(1'b1, 0);
    // end inside the format fields
    append_wav(32'h8000_0000, FMT_ID, 32'd16, rand_fields(), 0, 32'd1);
    send_file(1'b1, 30);
    // huge format length, then end
    header_prefix(32'd1, FMT_ID, 32'hFFFF_FFFF);
    put_fields(rand_fields());
    put_rand(6);
    send_file(1'b1, file_bytes.size() - 1);
    // huge skipped chunk, then end
    header_prefix(32'd2, FMT_ID, 32'd16);
    put_fields(rand_fields());
    put32(junk_id());
    put32(32'hFFFF_FFFF);
    put_rand(5);
    send_file(1'b1, file_bytes.size() - 1);
    // restart in the middle of a file
    append_wav(32'd3, FMT_ID, 32'd16, rand_fields(), 0, 32'd7);
    file_bytes = file_bytes[0:19];
    send_file(1'b1, -1);
    // zero-size chunk straight into data
    header_prefix(32'd4, FMT_ID, 32'd16);
    put_fields(rand_fields());
    put32(junk_id());
    put32(32'd0);
    put32(wav_hdr_pkg::TAG_DATA);
    put32(32'h0000_0100);
    send_file(1'b1, -1);
    // skip in format chunk plus two chunks
    append_wav(edge_word(), FMT_ID, 32'd20, rand_fields(), 2, edge_word());
    send_file(1'b1, -1);

    last_mode = 0;
    rnd_files = 0;
    while (bytes_sent < TARGET_BYTES || rnd_files < TARGET_FILES) begin
      mode = (rnd_files / 5) % 4;
      if (mode != last_mode) begin
        wait_drained();
        snd_idle_pct  = idle_pct_by_phase[mode];
        rcv_stall_pct = stall_pct_by_phase[mode];
        last_mode     = mode;
      end
      if (rnd_files == 0) hold_req = 1'b1;
      random_file();
      rnd_files++;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
